FILE: design/bptc_pkg.sv
// Shared constants and types for the barometric compensation pipeline.
`default_nettype none

package bptc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_BASE   = 3'd0,
        REG_OFF_BASE    = 3'd1,
        REG_SENS_TEMPCO = 3'd2,
        REG_OFF_TEMPCO  = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5
    } cfg_reg_t;

    localparam int COEF_W  = 16;
    localparam int RAW_W   = 24;
    localparam int TEMP_W  = 15;
    localparam int PRES_W  = 17;

    // Pipeline depth (input register through output register)
    localparam int NSTAGE  = 10;

    localparam logic signed [20:0] TEMP_REF    = 21'sd2000;
    localparam logic signed [18:0] VCOLD_SHIFT = 19'sd3500;  // TEMP + 1500 = u + 3500
    localparam logic signed [20:0] TEMP_MIN    = -21'sd4000;
    localparam logic signed [20:0] TEMP_MAX    = 21'sd8500;
    localparam logic [PRES_W-1:0]  PRES_MAX    = 17'd131071;

endpackage

`default_nettype wire

FILE: design/baro_pressure_temp_compensation.sv
// Top level: second-order barometric pressure / temperature compensation pipeline.
//
// Usage:
//   Input channel s_*: one beat carries a raw pressure and a raw temperature
//   reading. Result channel m_*: one beat per input beat, in order, carrying
//   temperature in 0.01 degC, pressure in Pa and a saturation flag.
//   Config channel cfg_*: writes one of the six 16-bit calibration words by
//   index (0..5); other indexes are dropped. cfg_ready is always high. Write
//   calibration only while no beat is in flight.
//   An accepted beat enters stage 0 and leaves on m_* from the stage 9 register.
//   Throughput: one beat per cycle while m_ready is high, set by a ten-stage
//   register pipeline with at most one multiplier between any two registers;
//   the D1*SENS product is split in two partial products, summed in the next stage.
//   Stalls: each stage holds while the one after it is full and stalled, so
//   when m_ready is low the pipeline keeps filling its bubbles and s_ready
//   drops only once every stage holds a beat. Nothing is lost or repeated.
//   Reset (aresetn low, synchronous): all stages empty, calibration words 0.
`default_nettype none

module baro_pressure_temp_compensation (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // configuration write
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [bptc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [bptc_pkg::COEF_W-1:0]          cfg_data,
    // input beats
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [bptc_pkg::RAW_W-1:0]           s_raw_pressure,
    input  wire  [bptc_pkg::RAW_W-1:0]           s_raw_temperature,
    // result beats
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [bptc_pkg::TEMP_W-1:0]   m_temp_centideg,
    output logic [bptc_pkg::PRES_W-1:0]          m_pressure_pa,
    output logic                                 m_clamped
);

    localparam int NS = bptc_pkg::NSTAGE;

    // calibration words
    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bptc_pkg::REG_SENS_BASE:   c1_reg <= cfg_data;
                bptc_pkg::REG_OFF_BASE:    c2_reg <= cfg_data;
                bptc_pkg::REG_SENS_TEMPCO: c3_reg <= cfg_data;
                bptc_pkg::REG_OFF_TEMPCO:  c4_reg <= cfg_data;
                bptc_pkg::REG_REF_TEMP:    c5_reg <= cfg_data;
                bptc_pkg::REG_TEMP_SLOPE:  c6_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valid bits and per-stage advance
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_valid;
            for (int i = 1; i < NS; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // signed views of the coefficients used as multiplier operands
    logic signed [16:0] c3_s, c4_s, c6_s;
    assign c3_s = {1'b0, c3_reg};
    assign c4_s = {1'b0, c4_reg};
    assign c6_s = {1'b0, c6_reg};

    // ------------------------------------------------------------------
    // stage 0: capture, dT = D2 - C5*256
    logic [23:0]        d1_0_reg;
    logic signed [24:0] dt_0_reg;
    logic signed [24:0] dt_0_next;

    assign dt_0_next = $signed({1'b0, s_raw_temperature}) - $signed({1'b0, c5_reg, 8'h00});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_0_reg <= s_raw_pressure;
            dt_0_reg <= dt_0_next;
        end
    end

    // stage 1: the four dT products
    logic [23:0]        d1_1_reg;
    logic signed [41:0] pt_1_reg, po_1_reg, ps_1_reg;
    logic signed [49:0] pdd_1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            d1_1_reg  <= d1_0_reg;
            pt_1_reg  <= dt_0_reg * c6_s;
            po_1_reg  <= dt_0_reg * c4_s;
            ps_1_reg  <= dt_0_reg * c3_s;
            pdd_1_reg <= dt_0_reg * dt_0_reg;
        end
    end

    // stage 2: first-order OFF, SENS; u = TEMP - 2000; T2
    logic [23:0]        d1_2_reg;
    logic signed [18:0] u_2_reg, up_2_reg;
    logic signed [39:0] off_2_reg, sens_2_reg;
    logic [17:0]        t2_2_reg;
    logic signed [18:0] u_2_next;
    logic signed [39:0] off_2_next, sens_2_next;

    assign u_2_next    = pt_1_reg[41:23];  // floor(dT*C6 / 2^23)
    assign off_2_next  = {8'h00, c2_reg, 16'h0000} + {{5{po_1_reg[41]}}, po_1_reg[41:7]};
    assign sens_2_next = {9'h000, c1_reg, 15'h0000} + {{6{ps_1_reg[41]}}, ps_1_reg[41:8]};

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            d1_2_reg   <= d1_1_reg;
            u_2_reg    <= u_2_next;
            up_2_reg   <= u_2_next + bptc_pkg::VCOLD_SHIFT;
            off_2_reg  <= off_2_next;
            sens_2_reg <= sens_2_next;
            t2_2_reg   <= pdd_1_reg[48:31];  // dT^2 >= 0, floor(dT^2 / 2^31)
        end
    end

    // stage 3: squares, final temperature
    logic [23:0]        d1_3_reg;
    logic [34:0]        a_3_reg, b_3_reg;
    logic               cold_3_reg, vcold_3_reg;
    logic signed [39:0] off_3_reg, sens_3_reg;
    logic signed [20:0] temp_3_reg;
    logic signed [37:0] a_3_next, b_3_next;
    logic [17:0]        t2_sel;

    assign a_3_next = u_2_reg * u_2_reg;
    assign b_3_next = up_2_reg * up_2_reg;
    assign t2_sel   = u_2_reg[18] ? t2_2_reg : '0;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            d1_3_reg    <= d1_2_reg;
            a_3_reg     <= a_3_next[34:0];
            b_3_reg     <= b_3_next[34:0];
            cold_3_reg  <= u_2_reg[18];
            vcold_3_reg <= up_2_reg[18];
            off_3_reg   <= off_2_reg;
            sens_3_reg  <= sens_2_reg;
            temp_3_reg  <= bptc_pkg::TEMP_REF + {{2{u_2_reg[18]}}, u_2_reg}
                           - $signed({3'b000, t2_sel});
        end
    end

    // stage 4: OFF2, SENS2
    logic [23:0]        d1_4_reg;
    logic signed [39:0] off_4_reg, sens_4_reg;
    logic signed [20:0] temp_4_reg;
    logic [37:0]        off2_4_reg, sens2_4_reg;
    logic [36:0]        a5;
    logic [37:0]        b7, b11, b7_sel, b11h_sel;

    assign a5       = {a_3_reg, 2'b00} + {2'b00, a_3_reg};
    assign b7       = {b_3_reg, 3'b000} - {3'b000, b_3_reg};
    assign b11      = {b_3_reg, 3'b000} + {2'b00, b_3_reg, 1'b0} + {3'b000, b_3_reg};
    assign b7_sel   = vcold_3_reg ? b7 : '0;
    assign b11h_sel = vcold_3_reg ? {1'b0, b11[37:1]} : '0;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            d1_4_reg    <= d1_3_reg;
            off_4_reg   <= off_3_reg;
            sens_4_reg  <= sens_3_reg;
            temp_4_reg  <= temp_3_reg;
            off2_4_reg  <= cold_3_reg ? ({1'b0, a5[36:1]} + b7_sel) : '0;
            sens2_4_reg <= cold_3_reg ? ({2'b00, a5[36:2]} + b11h_sel) : '0;
        end
    end

    // stage 5: apply second-order terms
    logic [23:0]        d1_5_reg;
    logic signed [39:0] off_5_reg, sens_5_reg;
    logic signed [20:0] temp_5_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            d1_5_reg   <= d1_4_reg;
            off_5_reg  <= off_4_reg - $signed({2'b00, off2_4_reg});
            sens_5_reg <= sens_4_reg - $signed({2'b00, sens2_4_reg});
            temp_5_reg <= temp_4_reg;
        end
    end

    // stage 6: D1*SENS as two partial products
    logic signed [39:0] off_6_reg;
    logic signed [20:0] temp_6_reg;
    logic [43:0]        pl_6_reg;
    logic signed [44:0] ph_6_reg;
    logic signed [24:0] d1_s;
    logic signed [19:0] sens_hi;

    assign d1_s    = {1'b0, d1_5_reg};
    assign sens_hi = sens_5_reg[39:20];

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            off_6_reg  <= off_5_reg;
            temp_6_reg <= temp_5_reg;
            pl_6_reg   <= d1_5_reg * sens_5_reg[19:0];
            ph_6_reg   <= d1_s * sens_hi;
        end
    end

    // stage 7: sum partial products (|high part| < 2^43)
    logic signed [39:0] off_7_reg;
    logic signed [20:0] temp_7_reg;
    logic signed [63:0] prod_7_reg;

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            off_7_reg  <= off_6_reg;
            temp_7_reg <= temp_6_reg;
            prod_7_reg <= {ph_6_reg[43:0], 20'h00000} + {20'h00000, pl_6_reg};
        end
    end

    // stage 8: P = ((D1*SENS >> 21) - OFF) >> 15
    logic signed [20:0] temp_8_reg;
    logic signed [28:0] p_8_reg;
    logic signed [43:0] diff;

    assign diff = {prod_7_reg[63], prod_7_reg[63:21]} - {{4{off_7_reg[39]}}, off_7_reg};

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            temp_8_reg <= temp_7_reg;
            p_8_reg    <= diff[43:15];
        end
    end

    // stage 9: saturate, output register
    logic               t_lo, t_hi, p_lo, p_hi;
    logic signed [20:0] temp_sat;

    assign t_lo = temp_8_reg < bptc_pkg::TEMP_MIN;
    assign t_hi = temp_8_reg > bptc_pkg::TEMP_MAX;
    assign p_lo = p_8_reg[28];
    assign p_hi = !p_8_reg[28] && (p_8_reg[27:17] != '0);
    assign temp_sat = t_lo ? bptc_pkg::TEMP_MIN : (t_hi ? bptc_pkg::TEMP_MAX : temp_8_reg);

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            m_temp_centideg <= temp_sat[14:0];
            m_pressure_pa   <= p_lo ? '0 : (p_hi ? bptc_pkg::PRES_MAX : p_8_reg[16:0]);
            m_clamped       <= t_lo || t_hi || p_lo || p_hi;
        end
    end

endmodule

`default_nettype wire

FILE: design/bptc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
`default_nettype none

module bptc_checker (
    input wire                                  aclk,
    input wire                                  aresetn,
    input wire                                  m_valid,
    input wire                                  m_ready,
    input wire signed [bptc_pkg::TEMP_W-1:0]    m_temp_centideg,
    input wire [bptc_pkg::PRES_W-1:0]           m_pressure_pa,
    input wire                                  m_clamped
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // temperature always within its saturation limits
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_temp_centideg) >= $signed(bptc_pkg::TEMP_MIN[14:0]) &&
                     $signed(m_temp_centideg) <= $signed(bptc_pkg::TEMP_MAX[14:0])))
        else $error("temperature outside saturation range");

    // flag set only when some value sits at a limit
    a_clamp_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clamped) |->
            (m_temp_centideg == bptc_pkg::TEMP_MIN[14:0] ||
             m_temp_centideg == bptc_pkg::TEMP_MAX[14:0] ||
             m_pressure_pa == '0 || m_pressure_pa == bptc_pkg::PRES_MAX))
        else $error("clamped flag without a saturated value");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pressure_pa) &&
                                   $stable(m_temp_centideg) && $stable(m_clamped)))
        else $error("result beat changed while stalled");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_baro_pressure_temp_compensation.sv
// Self-checking testbench for the barometric pressure/temperature compensation pipeline.
module tb_baro_pressure_temp_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_IDX_W = bptc_pkg::CFG_IDX_W;
    localparam int COEF_W    = bptc_pkg::COEF_W;
    localparam int RAW_W     = bptc_pkg::RAW_W;
    localparam int TEMP_W    = bptc_pkg::TEMP_W;
    localparam int PRES_W    = bptc_pkg::PRES_W;

    localparam int CLK_PERIOD   = 8;
    localparam int IDLE_PCT     = 13;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 160;
    localparam int BURST_ITEMS  = 150;

    // indexes past the last calibration word; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    localparam logic [COEF_W-1:0] CAL_TYPICAL [0:5] =
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
        logic                     clamped;
    } reading_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [COEF_W-1:0]         cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [RAW_W-1:0]          s_raw_pressure = '0;
    logic [RAW_W-1:0]          s_raw_temperature = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [TEMP_W-1:0]  m_temp_centideg;
    logic [PRES_W-1:0]         m_pressure_pa;
    logic                      m_clamped;

    logic [COEF_W-1:0] cal [0:5] = '{default: '0};
    reading_t          pending_readings [$];
    int                mismatches = 0;
    int                stall_cycles = 0;
    bit                no_idle = 1'b0;

    baro_pressure_temp_compensation dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_pressure    (s_raw_pressure),
        .s_raw_temperature (s_raw_temperature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_temp_centideg   (m_temp_centideg),
        .m_pressure_pa     (m_pressure_pa),
        .m_clamped         (m_clamped)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // second-order compensation; >>> on longint floors like the scheme requires
    function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
        longint d1, dt, t, off, sens, t2, off2, sens2, sq, p;
        reading_t r;
        d1    = longint'(d1_raw);
        dt    = longint'(d2_raw) - longint'(cal[bptc_pkg::REG_REF_TEMP]) * 256;
        t     = 2000 + ((dt * longint'(cal[bptc_pkg::REG_TEMP_SLOPE])) >>> 23);
        off   = longint'(cal[bptc_pkg::REG_OFF_BASE]) * 65536
              + ((longint'(cal[bptc_pkg::REG_OFF_TEMPCO]) * dt) >>> 7);
        sens  = longint'(cal[bptc_pkg::REG_SENS_BASE]) * 32768
              + ((longint'(cal[bptc_pkg::REG_SENS_TEMPCO]) * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (t < 2000) begin
            sq    = (t - 2000) * (t - 2000);
            t2    = (dt * dt) >>> 31;
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (t < -1500) begin
                sq    = (t + 1500) * (t + 1500);
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        t    = t - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = (((d1 * sens) >>> 21) - off) >>> 15;
        r.clamped = 1'b0;
        if (t < longint'(bptc_pkg::TEMP_MIN)) begin
            t = longint'(bptc_pkg::TEMP_MIN);
            r.clamped = 1'b1;
        end
        if (t > longint'(bptc_pkg::TEMP_MAX)) begin
            t = longint'(bptc_pkg::TEMP_MAX);
            r.clamped = 1'b1;
        end
        if (p < 0) begin
            p = 0;
            r.clamped = 1'b1;
        end else if (p > longint'(bptc_pkg::PRES_MAX)) begin
            p = longint'(bptc_pkg::PRES_MAX);
            r.clamped = 1'b1;
        end
        r.temp = t[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result beat: temp %0d pres %0d clamped %0b",
                         $time, m_temp_centideg, m_pressure_pa, m_clamped);
            end else begin
                want = pending_readings.pop_front();
                if (m_temp_centideg !== want.temp) begin
                    mismatches++;
                    $display("%0t temp_centideg expected %0d actual %0d",
                             $time, want.temp, m_temp_centideg);
                end
                if (m_pressure_pa !== want.pres) begin
                    mismatches++;
                    $display("%0t pressure_pa expected %0d actual %0d",
                             $time, want.pres, m_pressure_pa);
                end
                if (m_clamped !== want.clamped) begin
                    mismatches++;
                    $display("%0t clamped expected %0b actual %0b",
                             $time, want.clamped, m_clamped);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("baro_pressure_temp_compensation: mismatch");
            $finish;
        end
    end

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= bptc_pkg::REG_TEMP_SLOPE)
            cal[idx] = data;
    endtask

    task automatic load_cal(input logic [COEF_W-1:0] words [0:5]);
        for (int i = 0; i <= 5; i++)
            write_coef(CFG_IDX_W'(i), words[i]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_raw_pressure    <= d1;
        s_raw_temperature <= d2;
        do @(posedge aclk); while (!s_ready);
        pending_readings.push_back(compensate(d1, d2));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (bptc_pkg::NSTAGE + 2) @(posedge aclk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef(input logic [COEF_W-1:0] typical,
                                                    input bit near_typical);
        if (near_typical)
            return typical + COEF_W'($urandom_range(8191)) - COEF_W'(4096);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // half uniform, half within 3000000 counts of the reference reading C5*256
    function automatic logic [RAW_W-1:0] pick_raw_temp();
        longint v;
        if ($urandom_range(1))
            return RAW_W'($urandom);
        v = longint'(cal[bptc_pkg::REG_REF_TEMP]) * 256
          + longint'($urandom_range(6000000)) - 3000000;
        if (v < 0)
            v = 0;
        if (v > 64'hFF_FFFF)
            v = 64'hFF_FFFF;
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_pressure();
        if ($urandom_range(1))
            return RAW_W'($urandom);
        return RAW_W'($urandom_range(12000000, 4000000));
    endfunction

    task automatic test_reset_cal();
        send_reading(24'd9085466, 24'd8569150);
        send_reading(24'hFF_FFFF, 24'hFF_FFFF);
        drain_results();
    endtask

    task automatic test_typical_ranges();
        logic [RAW_W-1:0] d1s [14] = '{24'd9085466, 24'd9085466, 24'd9085466, 24'd9085466,
                                       24'd9085466, 24'd9085466, 24'd9085466, 24'd0,
                                       24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF,
                                       24'h55_5555, 24'hAA_AAAA};
        // nominal, dT zero, just below 20 C, cold, very cold, low and high clamp, ...
        logic [RAW_W-1:0] d2s [14] = '{24'd8569150, 24'd8566784, 24'd8566783, 24'd7800000,
                                       24'd7500000, 24'd6500000, 24'd11000000, 24'd8569150,
                                       24'd8569150, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF,
                                       24'hAA_AAAA, 24'h55_5555};
        load_cal(CAL_TYPICAL);
        for (int i = 0; i < 14; i++)
            send_reading(d1s[i], d2s[i]);
        drain_results();
    endtask

    task automatic test_unused_index();
        write_coef(REG_NONE_LO, 16'h1234);
        write_coef(REG_NONE_HI, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_reading(24'd9085466, 24'd8569150);
        send_reading(24'd8000000, 24'd7700000);
        drain_results();
    endtask

    task automatic test_cal_extremes();
        logic [COEF_W-1:0] all_ones [0:5] = '{default: '1};
        logic [COEF_W-1:0] alt_words [0:5] = '{16'h0000, 16'hFFFF, 16'h0000,
                                               16'hFFFF, 16'h0000, 16'hFFFF};
        load_cal(all_ones);
        send_reading(24'd0, 24'd0);
        send_reading(24'hFF_FFFF, 24'hFF_FFFF);
        send_reading(24'hFF_FFFF, 24'd0);
        drain_results();
        load_cal(alt_words);
        send_reading(24'd0, 24'hFF_FFFF);
        send_reading(24'hFF_FFFF, 24'd0);
        send_reading(24'h80_0000, 24'h7F_FFFF);
        drain_results();
    endtask

    task automatic test_random_cal(input bit near_typical, input int n_items);
        logic [COEF_W-1:0] words [0:5];
        for (int i = 0; i <= 5; i++)
            words[i] = pick_coef(CAL_TYPICAL[i], near_typical);
        load_cal(words);
        repeat (n_items)
            send_reading(pick_raw_pressure(), pick_raw_temp());
        drain_results();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        load_cal(CAL_TYPICAL);
        repeat (BURST_ITEMS)
            send_reading(pick_raw_pressure(), pick_raw_temp());
        drain_results();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_cal();
        test_typical_ranges();
        test_unused_index();
        test_cal_extremes();
        for (int ph = 0; ph < 8; ph++)
            test_random_cal(ph % 2 == 0, PHASE_ITEMS);
        test_back_to_back();
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("baro_pressure_temp_compensation: match");
        else
            $display("baro_pressure_temp_compensation: mismatch");
        $finish;
    end

endmodule
